@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the bitmap run finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ hw/rtl/abrf_pkg.sv @@
// Types and constants of the address bitmap run finder.
package abrf_pkg;

  localparam int unsigned BITS      = 128;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned IDX_W     = $clog2(BITS);
  localparam int unsigned CNT_W     = $clog2(BITS + 1);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);
  localparam int unsigned QOCC_W    = QCNT_W + 1;

  localparam logic [ADDR_W-1:0] BITS_A  = ADDR_W'(BITS);
  localparam logic [ADDR_W-1:0] BITS_M1 = ADDR_W'(BITS - 1);
  localparam logic [CNT_W-1:0]  BITS_C  = CNT_W'(BITS);

  localparam logic [CFG_IDX_W-1:0] REG_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LAST = CFG_IDX_W'(1);

  localparam logic [ADDR_W-1:0] BASE_RST = '0;
  localparam logic [ADDR_W-1:0] LAST_RST = ADDR_W'(127);

  typedef enum logic [1:0] {
    FUNC_READ,
    FUNC_WRITE,
    FUNC_RUNS,
    FUNC_NOP
  } func_e;

  typedef enum logic [1:0] {
    ST_OPS,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    func_e             func;
    logic              value;
    logic              in_win;
    logic [IDX_W-1:0]  off;
    logic [CNT_W-1:0]  entries;
  } op_t;

  typedef struct packed {
    logic              bit_read;
    logic              out_of_range;
    logic [ADDR_W-1:0] run_start;
    logic [ADDR_W-1:0] run_end;
    logic              run_found;
    logic              last_result;
  } res_t;

endpackage

@@ hw/rtl/abrf_ifs.sv @@
// Channel interfaces of the address bitmap run finder.
interface abrf_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic [abrf_pkg::ADDR_W-1:0] address;
  logic                       value;

  modport source (output valid, func, address, value, input ready);
  modport sink (input valid, func, address, value, output ready);
endinterface

interface abrf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       bit_read;
  logic                       out_of_range;
  logic [abrf_pkg::ADDR_W-1:0] run_start;
  logic [abrf_pkg::ADDR_W-1:0] run_end;
  logic                       run_found;
  logic                       last_result;

  modport source (output valid, bit_read, out_of_range, run_start, run_end, run_found,
                  last_result, input ready);
  modport sink (input valid, bit_read, out_of_range, run_start, run_end, run_found,
                last_result, output ready);
endinterface

interface abrf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [abrf_pkg::CFG_IDX_W-1:0] index;
  logic [abrf_pkg::ADDR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/address_bitmap_run_finder.sv @@
// Top level of the address bitmap run finder.
//
// The block holds one flag per address over a window of up to BITS addresses that starts
// at the base address register. Input beats carry func, address and value: a read returns
// the stored flag, a write stores one, and a run listing walks the window in ascending
// order and returns one result beat per maximal run of flags equal to value. Every input
// beat yields result beats in order; the final one has last_result set.
// The configuration channel writes base and last address; it is always ready and is meant
// to be used only while no item is in flight.
// Reads, writes and unused codes sustain one beat per cycle while the result buffer has
// room; each passes the input queue, the stage register and the result buffer in turn.
// A listing holds the back end while the bitmap RAM yields its window entries, one per
// cycle while the buffer has room; input beats queue in a two-entry queue meanwhile.
// Reset clears every flag at once through per-entry valid bits, so no clearing pass runs,
// and loads base 0 and last 127. A stalled receiver fills the two-entry result buffer and
// then holds the back end, and through the queue, the input.
module address_bitmap_run_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  abrf_in_if.sink     in_i,
  abrf_out_if.source  res_o,
  abrf_cfg_if.sink    cfg_i
);

  logic [abrf_pkg::ADDR_W-1:0] base_q;
  logic [abrf_pkg::ADDR_W-1:0] last_q;
  logic                        op_vld;
  logic                        op_rdy;
  abrf_pkg::op_t               op;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= abrf_pkg::BASE_RST;
      last_q <= abrf_pkg::LAST_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        abrf_pkg::REG_BASE: begin
          base_q <= cfg_i.data;
        end
        abrf_pkg::REG_LAST: begin
          last_q <= cfg_i.data;
        end
        default: begin
        end
      endcase
    end
  end

  abrf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .base_i   (base_q),
    .last_i   (last_q),
    .in_i     (in_i),
    .op_vld_o (op_vld),
    .op_rdy_i (op_rdy),
    .op_o     (op)
  );

  abrf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .base_i   (base_q),
    .op_vld_i (op_vld),
    .op_rdy_o (op_rdy),
    .op_i     (op),
    .res_o    (res_o)
  );

endmodule

@@ hw/rtl/abrf_ram.sv @@
// Generic single-write, registered-read RAM.
module abrf_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/abrf_front.sv @@
// Front end: accepts input beats, checks them against the window and queues them.
`include "assert_macros.svh"

module abrf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [abrf_pkg::ADDR_W-1:0] base_i,
  input  logic [abrf_pkg::ADDR_W-1:0] last_i,
  abrf_in_if.sink                     in_i,
  output logic                        op_vld_o,
  input  logic                        op_rdy_i,
  output abrf_pkg::op_t               op_o
);

  logic [abrf_pkg::ADDR_W:0]   adiff;
  logic [abrf_pkg::ADDR_W:0]   sdiff;
  logic                        in_win;
  logic [abrf_pkg::CNT_W-1:0]  entries;
  abrf_pkg::op_t               op_new;
  abrf_pkg::op_t               q_q [abrf_pkg::QDEPTH];
  logic [abrf_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [abrf_pkg::QCNT_W-1:0] cnt_q;
  logic                        push, pop;

  assign adiff = {1'b0, in_i.address} - {1'b0, base_i};
  assign sdiff = {1'b0, last_i} - {1'b0, base_i};

  always_comb begin
    in_win = !sdiff[abrf_pkg::ADDR_W] && !adiff[abrf_pkg::ADDR_W] &&
             (adiff[abrf_pkg::ADDR_W-1:0] <= sdiff[abrf_pkg::ADDR_W-1:0]) &&
             (adiff[abrf_pkg::ADDR_W-1:0] < abrf_pkg::BITS_A);
    if (sdiff[abrf_pkg::ADDR_W]) begin
      entries = '0;
    end else if (sdiff[abrf_pkg::ADDR_W-1:0] >= abrf_pkg::BITS_M1) begin
      entries = abrf_pkg::BITS_C;
    end else begin
      entries = sdiff[abrf_pkg::CNT_W-1:0] + 1'b1;
    end
    op_new.func    = abrf_pkg::func_e'(in_i.func);
    op_new.value   = in_i.value;
    op_new.in_win  = in_win;
    op_new.off     = adiff[abrf_pkg::IDX_W-1:0];
    op_new.entries = entries;
  end

  assign in_i.ready = (cnt_q != abrf_pkg::QCNT_W'(abrf_pkg::QDEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign op_vld_o   = (cnt_q != '0);
  assign pop        = op_vld_o && op_rdy_i;
  assign op_o       = q_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == abrf_pkg::QPTR_W'(abrf_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == abrf_pkg::QPTR_W'(abrf_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= op_new;
    end
  end

  `ASSERT_NEVER(a_entries_bound, clk_i, rst_ni, op_vld_o && (op_o.entries > abrf_pkg::BITS_C))
  `ASSERT_CLK(a_pop_needs_entry, clk_i, rst_ni, pop |-> (cnt_q != '0))
  `ASSERT_CLK(a_push_counts, clk_i, rst_ni, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))

endmodule

@@ hw/rtl/abrf_back.sv @@
// Back end: runs reads, writes and run listings on the bitmap and buffers result beats.
`include "assert_macros.svh"

module abrf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [abrf_pkg::ADDR_W-1:0] base_i,
  input  logic                        op_vld_i,
  output logic                        op_rdy_o,
  input  abrf_pkg::op_t               op_i,
  abrf_out_if.source                  res_o
);

  typedef struct packed {
    logic                       vld;
    abrf_pkg::func_e            kind;
    logic                       in_win;
    logic                       vbit;
    logic [abrf_pkg::IDX_W-1:0] idx;
  } stage_t;

  abrf_pkg::state_e            state_q, state_d;
  stage_t                      s1_q, s1_d;
  logic [abrf_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [abrf_pkg::CNT_W-1:0]  ent_q, ent_d;
  logic                        val_q, val_d;
  logic                        running_q, running_d;
  logic                        pvld_q, pvld_d;
  logic [abrf_pkg::IDX_W-1:0]  rstart_q, rstart_d;
  logic [abrf_pkg::IDX_W-1:0]  pstart_q, pstart_d;
  logic [abrf_pkg::IDX_W-1:0]  pend_q, pend_d;
  logic [abrf_pkg::BITS-1:0]   vld_q;
  logic                        vld_set;

  logic                        ram_we;
  logic [abrf_pkg::IDX_W-1:0]  ram_addr;
  logic                        ram_wdata;
  logic                        ram_rdata;

  abrf_pkg::res_t              ofifo_q [abrf_pkg::QDEPTH];
  logic [abrf_pkg::QPTR_W-1:0] owr_q, ord_q;
  logic [abrf_pkg::QCNT_W-1:0] ocnt_q;
  logic                        pop, push, room;
  logic [abrf_pkg::QOCC_W-1:0] occ;

  logic                        bitv, match;
  logic                        pbit, poor, pfound, plast;
  logic [abrf_pkg::IDX_W-1:0]  ps_off, pe_off;
  abrf_pkg::res_t              push_res;
  abrf_pkg::res_t              head;

  abrf_ram #(
    .WIDTH (1),
    .DEPTH (abrf_pkg::BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  assign pop  = res_o.valid && res_o.ready;
  assign occ  = {1'b0, ocnt_q} + abrf_pkg::QOCC_W'(s1_q.vld) - abrf_pkg::QOCC_W'(pop);
  assign room = (occ < abrf_pkg::QOCC_W'(abrf_pkg::QDEPTH));
  assign bitv  = s1_q.vbit & ram_rdata;
  assign match = (bitv == val_q);

  always_comb begin
    state_d   = state_q;
    s1_d      = '0;
    cnt_d     = cnt_q;
    ent_d     = ent_q;
    val_d     = val_q;
    running_d = running_q;
    pvld_d    = pvld_q;
    rstart_d  = rstart_q;
    pstart_d  = pstart_q;
    pend_d    = pend_q;
    op_rdy_o  = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = op_i.off;
    ram_wdata = op_i.value;
    vld_set   = 1'b0;
    push      = 1'b0;
    pbit      = 1'b0;
    poor      = 1'b0;
    pfound    = 1'b0;
    plast     = 1'b0;
    ps_off    = '0;
    pe_off    = '0;

    if (s1_q.vld) begin
      case (s1_q.kind)
        abrf_pkg::FUNC_READ: begin
          push  = 1'b1;
          pbit  = s1_q.in_win & bitv;
          poor  = !s1_q.in_win;
          plast = 1'b1;
        end
        abrf_pkg::FUNC_WRITE: begin
          push  = 1'b1;
          poor  = !s1_q.in_win;
          plast = 1'b1;
        end
        abrf_pkg::FUNC_RUNS: begin
          if (!running_q && match) begin
            running_d = 1'b1;
            rstart_d  = s1_q.idx;
          end else if (running_q && !match) begin
            running_d = 1'b0;
            pvld_d    = 1'b1;
            pstart_d  = rstart_q;
            pend_d    = s1_q.idx - 1'b1;
            if (pvld_q) begin
              push   = 1'b1;
              pfound = 1'b1;
              ps_off = pstart_q;
              pe_off = pend_q;
            end
          end
        end
        default: begin
          push  = 1'b1;
          plast = 1'b1;
        end
      endcase
    end

    case (state_q)
      abrf_pkg::ST_OPS: begin
        if (op_vld_i && room) begin
          op_rdy_o = 1'b1;
          if (op_i.func == abrf_pkg::FUNC_RUNS) begin
            val_d     = op_i.value;
            ent_d     = op_i.entries;
            cnt_d     = '0;
            running_d = 1'b0;
            pvld_d    = 1'b0;
            state_d   = (op_i.entries == '0) ? abrf_pkg::ST_DRAIN : abrf_pkg::ST_SCAN;
          end else begin
            s1_d.vld    = 1'b1;
            s1_d.kind   = op_i.func;
            s1_d.in_win = op_i.in_win;
            s1_d.vbit   = vld_q[op_i.off];
            s1_d.idx    = op_i.off;
            if (op_i.func == abrf_pkg::FUNC_WRITE && op_i.in_win) begin
              ram_we  = 1'b1;
              vld_set = 1'b1;
            end
          end
        end
      end
      abrf_pkg::ST_SCAN: begin
        if (room) begin
          ram_addr    = cnt_q[abrf_pkg::IDX_W-1:0];
          s1_d.vld    = 1'b1;
          s1_d.kind   = abrf_pkg::FUNC_RUNS;
          s1_d.in_win = 1'b1;
          s1_d.vbit   = vld_q[cnt_q[abrf_pkg::IDX_W-1:0]];
          s1_d.idx    = cnt_q[abrf_pkg::IDX_W-1:0];
          cnt_d       = cnt_q + 1'b1;
          if (cnt_q == ent_q - 1'b1) begin
            state_d = abrf_pkg::ST_DRAIN;
          end
        end
      end
      abrf_pkg::ST_DRAIN: begin
        if (!s1_q.vld) begin
          state_d = abrf_pkg::ST_FINISH;
        end
      end
      abrf_pkg::ST_FINISH: begin
        if (room) begin
          if (running_q) begin
            running_d = 1'b0;
            pvld_d    = 1'b1;
            pstart_d  = rstart_q;
            pend_d    = abrf_pkg::IDX_W'(ent_q - 1'b1);
            if (pvld_q) begin
              push   = 1'b1;
              pfound = 1'b1;
              ps_off = pstart_q;
              pe_off = pend_q;
            end
          end else begin
            push    = 1'b1;
            plast   = 1'b1;
            pfound  = pvld_q;
            ps_off  = pstart_q;
            pe_off  = pend_q;
            state_d = abrf_pkg::ST_OPS;
          end
        end
      end
      default: begin
        state_d = abrf_pkg::ST_OPS;
      end
    endcase
  end

  always_comb begin
    push_res.bit_read     = pbit;
    push_res.out_of_range = poor;
    push_res.run_start    = pfound ? base_i + abrf_pkg::ADDR_W'(ps_off) : '0;
    push_res.run_end      = pfound ? base_i + abrf_pkg::ADDR_W'(pe_off) : '0;
    push_res.run_found    = pfound;
    push_res.last_result  = plast;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= abrf_pkg::ST_OPS;
      s1_q      <= '0;
      cnt_q     <= '0;
      running_q <= 1'b0;
      pvld_q    <= 1'b0;
      vld_q     <= '0;
      owr_q     <= '0;
      ord_q     <= '0;
      ocnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      s1_q      <= s1_d;
      cnt_q     <= cnt_d;
      running_q <= running_d;
      pvld_q    <= pvld_d;
      if (vld_set) begin
        vld_q[op_i.off] <= 1'b1;
      end
      if (push) begin
        owr_q <= (owr_q == abrf_pkg::QPTR_W'(abrf_pkg::QDEPTH - 1)) ? '0 : owr_q + 1'b1;
      end
      if (pop) begin
        ord_q <= (ord_q == abrf_pkg::QPTR_W'(abrf_pkg::QDEPTH - 1)) ? '0 : ord_q + 1'b1;
      end
      if (push && !pop) begin
        ocnt_q <= ocnt_q + 1'b1;
      end else if (pop && !push) begin
        ocnt_q <= ocnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q    <= ent_d;
    val_q    <= val_d;
    rstart_q <= rstart_d;
    pstart_q <= pstart_d;
    pend_q   <= pend_d;
    if (push) begin
      ofifo_q[owr_q] <= push_res;
    end
  end

  assign head               = ofifo_q[ord_q];
  assign res_o.valid        = (ocnt_q != '0);
  assign res_o.bit_read     = head.bit_read;
  assign res_o.out_of_range = head.out_of_range;
  assign res_o.run_start    = head.run_start;
  assign res_o.run_end      = head.run_end;
  assign res_o.run_found    = head.run_found;
  assign res_o.last_result  = head.last_result;

  `ASSERT_CLK(a_push_has_room, clk_i, rst_ni, push |-> ((ocnt_q != abrf_pkg::QCNT_W'(abrf_pkg::QDEPTH)) || pop))
  `ASSERT_CLK(a_finish_pipe_empty, clk_i, rst_ni, (state_q == abrf_pkg::ST_FINISH) |-> !s1_q.vld)
  `ASSERT_CLK(a_scan_in_window, clk_i, rst_ni, (state_q == abrf_pkg::ST_SCAN) |-> (cnt_q < ent_q))

endmodule
